// ----- src/rbm_pkg.sv -----
`default_nettype none

package rbm_pkg;

  // Address width kept on the ROM side and the length of the unlock sequence
  localparam int unsigned AddrBits  = 22;
  localparam int unsigned RomAddrW  = 22;
  localparam int unsigned CountW    = 6;
  localparam logic [CountW-1:0] UnlockLen = CountW'(48);

  localparam logic [RomAddrW-1:0] AddrLimit =
      (AddrBits >= RomAddrW) ? {RomAddrW{1'b1}}
                             : RomAddrW'((64'd1 << AddrBits) - 64'd1);

  // Bus address map
  localparam logic [15:0] RomEnd      = 16'h8000;
  localparam logic [15:0] SwitchBase  = 16'h4000;
  localparam logic [15:0] InnerReg    = 16'h3F00;
  localparam logic [15:0] OuterReg    = 16'h3FC0;
  localparam logic [15:0] WramFirst   = 16'hC000;
  localparam logic [15:0] WramLast    = 16'hDFFF;
  localparam logic [15:0] LogoFirst   = 16'h0104;
  localparam logic [15:0] LogoEnd     = 16'h0134;

  // Configuration register indexes
  localparam logic CFG_ROM_MASK  = 1'b0;
  localparam logic CFG_BOOTSTRAP = 1'b1;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_NOTICE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    LOCK_DMG  = 2'd0,
    LOCK_CGB  = 2'd1,
    LOCK_OPEN = 2'd2
  } lock_mode_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic                rom_selected;
    logic [RomAddrW-1:0] rom_address;
    logic [7:0]          data_xor;
    logic [1:0]          lock_mode;
  } result_t;

  // XOR pattern over the header logo area
  function automatic logic [7:0] logo_xor(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0:  v = 8'hdf;  6'd1:  v = 8'hce;  6'd2:  v = 8'h97;  6'd3:  v = 8'h78;
      6'd4:  v = 8'hcd;  6'd5:  v = 8'h2f;  6'd6:  v = 8'hf0;  6'd7:  v = 8'h0b;
      6'd8:  v = 8'h0b;  6'd9:  v = 8'hea;  6'd10: v = 8'h78;  6'd11: v = 8'h83;
      6'd12: v = 8'h08;  6'd13: v = 8'h1d;  6'd14: v = 8'h9a;  6'd15: v = 8'h45;
      6'd16: v = 8'h11;  6'd17: v = 8'h2b;  6'd18: v = 8'he1;  6'd19: v = 8'h11;
      6'd20: v = 8'hf8;  6'd21: v = 8'h88;  6'd22: v = 8'hf8;  6'd23: v = 8'h8e;
      6'd24: v = 8'hfe;  6'd25: v = 8'h88;  6'd26: v = 8'h2a;  6'd27: v = 8'hc4;
      6'd28: v = 8'hff;  6'd29: v = 8'hfc;  6'd30: v = 8'hd9;  6'd31: v = 8'h87;
      6'd32: v = 8'h22;  6'd33: v = 8'hab;  6'd34: v = 8'h67;  6'd35: v = 8'h7d;
      6'd36: v = 8'h77;  6'd37: v = 8'h2c;  6'd38: v = 8'ha8;  6'd39: v = 8'hee;
      6'd40: v = 8'hff;  6'd41: v = 8'h9b;  6'd42: v = 8'h99;  6'd43: v = 8'h91;
      6'd44: v = 8'haa;  6'd45: v = 8'h9b;  6'd46: v = 8'h33;  6'd47: v = 8'h3e;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- src/rbm_core.sv -----
`default_nettype none

// Mapper state, configuration and the single-pass result logic.
module rbm_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [rbm_pkg::RomAddrW-1:0] cfg_data_i,
  input  wire logic                       fire_i,
  input  wire rbm_pkg::item_t             item_i,
  output rbm_pkg::result_t                res_o
);

  logic [rbm_pkg::RomAddrW-1:0] rom_mask_q;
  logic [7:0]                   inner_q, inner_d;
  logic [7:0]                   outer_q, outer_d;
  rbm_pkg::lock_mode_e          lock_q, lock_d;
  logic [rbm_pkg::CountW-1:0]   count_q, count_d;

  logic [rbm_pkg::CountW-1:0]   count_a;
  logic [7:0]                   bank;
  logic [rbm_pkg::RomAddrW-1:0] base;
  logic [5:0]                   logo_off;

  always_comb begin
    inner_d  = inner_q;
    outer_d  = outer_q;
    lock_d   = lock_q;
    count_d  = count_q;
    count_a  = count_q;
    bank     = outer_q;
    base     = '0;
    logo_off = item_i.address[5:0] - rbm_pkg::LogoFirst[5:0];
    res_o    = '0;

    unique case (item_i.action)
      rbm_pkg::ACT_READ: begin
        if (item_i.address < rbm_pkg::RomEnd) begin
          // unlock step: fire the mode change when the count is full
          if (count_q == rbm_pkg::UnlockLen) begin
            if (lock_q == rbm_pkg::LOCK_DMG) begin
              lock_d  = rbm_pkg::LOCK_CGB;
              count_a = '0;
            end else if (lock_q == rbm_pkg::LOCK_CGB) begin
              lock_d  = rbm_pkg::LOCK_OPEN;
            end
          end
          count_d = (count_a == rbm_pkg::UnlockLen) ? count_a : count_a + 1'b1;

          bank = (item_i.address < rbm_pkg::SwitchBase) ? outer_q : (outer_q | inner_q);
          base = {bank, 14'b0} & rom_mask_q;
          res_o.rom_selected = 1'b1;
          res_o.rom_address  = (base + {8'b0, item_i.address[13:0]}) & rbm_pkg::AddrLimit;
          if (lock_d == rbm_pkg::LOCK_CGB && item_i.address >= rbm_pkg::LogoFirst &&
              item_i.address < rbm_pkg::LogoEnd) begin
            res_o.data_xor = rbm_pkg::logo_xor(logo_off);
          end
        end
      end
      rbm_pkg::ACT_WRITE: begin
        if (item_i.address == rbm_pkg::InnerReg) begin
          inner_d = (item_i.write_data != 8'd0) ? item_i.write_data : 8'd1;
        end else if (item_i.address == rbm_pkg::OuterReg) begin
          outer_d = {item_i.write_data[3:0], 4'b0};
        end
      end
      rbm_pkg::ACT_NOTICE: begin
        if (lock_q == rbm_pkg::LOCK_DMG && item_i.address >= rbm_pkg::WramFirst &&
            item_i.address <= rbm_pkg::WramLast) begin
          lock_d  = rbm_pkg::LOCK_CGB;
          count_d = '0;
        end
      end
      default: begin
      end
    endcase

    res_o.lock_mode = lock_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_mask_q <= '1;
      inner_q    <= 8'd1;
      outer_q    <= 8'd0;
      lock_q     <= rbm_pkg::LOCK_DMG;
      count_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rbm_pkg::CFG_ROM_MASK: begin
          rom_mask_q <= cfg_data_i;
        end
        rbm_pkg::CFG_BOOTSTRAP: begin
          lock_q  <= cfg_data_i[0] ? rbm_pkg::LOCK_DMG : rbm_pkg::LOCK_OPEN;
          count_q <= '0;
        end
      endcase
    end else if (fire_i) begin
      inner_q <= inner_d;
      outer_q <= outer_d;
      lock_q  <= lock_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/rom_bank_mapper_with_logo_unlock.sv -----
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  action_i, address_i, write_data_i
// result    out        out_valid_o/out_stall_i rom_selected_o, rom_address_o,
//                                              data_xor_o, lock_mode_o
// config    in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// One transfer per cycle while the result side is not stalled; a result passes through
// the input register, then the result register, before it is valid.
// The mapper state updates as an item moves from the input register into the
// result register, so items see the state in strict arrival order.
// Reset restores bank 1 / outer bank 0, full ROM mask and locked-DMG mode.
// A stall on the result side holds a full result register and a full input register; the input side stalls only
// when both are full and the result is stalled.
module rom_bank_mapper_with_logo_unlock (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             rom_selected_o,
  output logic [21:0]      rom_address_o,
  output logic [7:0]       data_xor_o,
  output logic [1:0]       lock_mode_o,

  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [21:0] cfg_data_i
);

  logic             s1_valid_q;
  rbm_pkg::item_t   s1_item_q;
  logic             res_valid_q;
  rbm_pkg::result_t res_q;
  rbm_pkg::result_t res_d;

  logic adv_res;   // result register may load
  logic adv_in;    // input register may load

  assign adv_res    = !res_valid_q || !out_stall_i;
  assign adv_in     = !s1_valid_q || adv_res;
  assign in_stall_o = !adv_in;

  // Compute the result and commit the state when the item leaves the input register
  rbm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s1_valid_q && adv_res),
    .item_i     (s1_item_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv_res) begin
        res_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers: hold while stalled, no reset needed
  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      s1_item_q.action     <= action_i;
      s1_item_q.address    <= address_i;
      s1_item_q.write_data <= write_data_i;
    end
    if (adv_res && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign rom_selected_o = res_q.rom_selected;
  assign rom_address_o  = res_q.rom_address;
  assign data_xor_o     = res_q.data_xor;
  assign lock_mode_o    = res_q.lock_mode;

endmodule

`default_nettype wire
